/* rtl/ddvr_pkg.sv */
// ----------------------------------------------------------------------------
// ddvr_pkg: shared types and constants for the differential drive ramp
// Widths, register codes, sequencer states and reset values.
// ----------------------------------------------------------------------------
package ddvr_pkg;

   localparam int DATA_W = 32;   // signed Q16.16 speeds
   localparam int CFG_W  = 24;   // register width
   localparam int DT_W   = 16;   // tick elapsed time, Q0.16
   localparam int TMO_W  = 17;   // timeout counter, Q1.16
   localparam int IDX_W  = 3;

   // shared multiplier: signed A x signed B
   localparam int MUL_A_W = DATA_W + 1;
   localparam int MUL_B_W = CFG_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // divider: dividend is |angular| * threshold, divisor is |linear|
   localparam int DIV_N_W = DATA_W + CFG_W;
   localparam int DIV_Q_W = DATA_W;
   localparam int DIV_C_W = $clog2(DIV_Q_W);

   localparam logic [TMO_W-1:0] TIMEOUT_LOAD = TMO_W'(65536);

   localparam logic [CFG_W-1:0] FWD_LIMIT_RST   = CFG_W'(98304);
   localparam logic [CFG_W-1:0] REV_LIMIT_RST   = CFG_W'(16384);
   localparam logic [CFG_W-1:0] TURN_LIMIT_RST  = CFG_W'(51472);
   localparam logic [CFG_W-1:0] TURN_THRESH_RST = CFG_W'(32768);
   localparam logic [CFG_W-1:0] LIN_ACCEL_RST   = CFG_W'(98304);
   localparam logic [CFG_W-1:0] ANG_ACCEL_RST   = CFG_W'(68629);
   localparam logic [CFG_W-1:0] TRACK_RST       = CFG_W'(47514);

   typedef enum logic [IDX_W-1:0] {
      REG_FWD_LIMIT   = 3'd0,
      REG_REV_LIMIT   = 3'd1,
      REG_TURN_LIMIT  = 3'd2,
      REG_TURN_THRESH = 3'd3,
      REG_LIN_ACCEL   = 3'd4,
      REG_ANG_ACCEL   = 3'd5,
      REG_TRACK       = 3'd6
   } reg_idx_type;

   typedef enum logic {
      OP_DRIVE = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMD_MUL,
      ST_CMD_START,
      ST_CMD_DIV,
      ST_CMD_FIN,
      ST_LIN_MUL,
      ST_ANG_MUL,
      ST_ANG_RAMP,
      ST_WHL_MUL,
      ST_WHL_OUT
   } seq_state_type;

endpackage

/* rtl/ddvr_mul.sv */
// ----------------------------------------------------------------------------
// ddvr_mul: shared registered multiplier
// One signed multiply per cycle; product is registered.
// ----------------------------------------------------------------------------
module ddvr_mul (
   input  logic                                 clock,
   input  logic signed [ddvr_pkg::MUL_A_W-1:0]  a,
   input  logic signed [ddvr_pkg::MUL_B_W-1:0]  b,
   output logic signed [ddvr_pkg::MUL_P_W-1:0]  p
);
   import ddvr_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(a) * MUL_P_W'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign p = prod_ff;

endmodule

/* rtl/ddvr_div.sv */
// ----------------------------------------------------------------------------
// ddvr_div: restoring divider, one quotient bit per cycle
// Quotient is known to fit DIV_Q_W bits, so the upper dividend bits seed the
// remainder and only DIV_Q_W steps are run.
// ----------------------------------------------------------------------------
module ddvr_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ddvr_pkg::DIV_N_W-1:0]    dividend,
   input  logic [ddvr_pkg::CFG_W-1:0]      divisor,
   output logic                            done,
   output logic [ddvr_pkg::DIV_Q_W-1:0]    quotient
);
   import ddvr_pkg::*;

   logic               busy_ff, busy_in;
   logic [DIV_C_W-1:0] count_ff, count_in;
   logic [CFG_W-1:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0] work_ff, work_in;
   logic [CFG_W:0]     trial;
   logic               fits;
   logic               last;

   assign trial = {rem_ff, work_ff[DIV_Q_W-1]};
   assign fits  = trial >= {1'b0, divisor};
   assign last  = count_ff == DIV_C_W'(DIV_Q_W - 1);

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      work_in  = work_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = dividend[DIV_N_W-1:DIV_Q_W];
         work_in  = dividend[DIV_Q_W-1:0];
      end else if (busy_ff) begin
         rem_in   = fits ? CFG_W'(trial - {1'b0, divisor}) : trial[CFG_W-1:0];
         work_in  = {work_ff[DIV_Q_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
   end

   assign done     = busy_ff & last;
   assign quotient = work_ff;

endmodule

/* rtl/diff_drive_velocity_ramp.sv */
// ----------------------------------------------------------------------------
// diff_drive_velocity_ramp: trapezoidal speed ramp for a differential drive
// Drive requests set limited targets; tick requests ramp toward them and
// produce left/right wheel speeds.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per accept (req_valid high, req_stall low). op selects
//            drive (sets targets, arms, loads 1 s timeout) or tick (elapsed).
//   rsp_*  : wheel speeds, one result per armed tick with nonzero elapsed.
//   csr_*  : register writes, always ready; write only while idle.
// Sequence:
//   Drive without angular scaling finishes on accept. With scaling, it runs
//   the multiply, start, bit-serial divide (one quotient bit per cycle, 32
//   bits) and finish steps.
//   Tick: steps LIN_MUL, ANG_MUL, ANG_RAMP, WHL_MUL and WHL_OUT, with three
//   passes through the single shared multiplier.
//   req_stall is high while a request is in progress.
// Output: a result sits in an output register until taken; the next request
//   is accepted meanwhile, and a tick that finishes while the register is
//   still stalled waits in its last step.
// Reset: registers return to defaults, targets, ramps and timeout clear, the
//   block is unarmed and no result is pending.
// ----------------------------------------------------------------------------
module diff_drive_velocity_ramp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic                                  req_enable,
   input  logic signed [ddvr_pkg::DATA_W-1:0]    req_linear_cmd,
   input  logic signed [ddvr_pkg::DATA_W-1:0]    req_angular_cmd,
   input  logic [ddvr_pkg::DT_W-1:0]             req_elapsed,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ddvr_pkg::DATA_W-1:0]    rsp_left_speed,
   output logic signed [ddvr_pkg::DATA_W-1:0]    rsp_right_speed,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ddvr_pkg::IDX_W-1:0]            csr_index,
   input  logic [ddvr_pkg::CFG_W-1:0]            csr_data
);
   import ddvr_pkg::*;

   localparam int WIDE_W = DATA_W + 10;

   function automatic logic signed [DATA_W-1:0] clamp_turn(
      input logic signed [DATA_W:0] v,
      input logic [CFG_W-1:0]       lim
   );
      logic signed [DATA_W:0] pos;
      pos = $signed({9'b0, lim});
      if (v > pos)       return pos[DATA_W-1:0];
      else if (v < -pos) return DATA_W'(-pos);
      else               return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] ramp_next(
      input logic signed [DATA_W-1:0] cur,
      input logic signed [DATA_W-1:0] tgt,
      input logic                     no_limit,
      input logic [CFG_W-1:0]         step
   );
      logic signed [DATA_W:0] diff;
      logic signed [DATA_W:0] st;
      diff = $signed({tgt[DATA_W-1], tgt}) - $signed({cur[DATA_W-1], cur});
      st   = $signed({9'b0, step});
      if (diff == 0 || no_limit) return tgt;
      if (diff > 0) return (diff > st) ? DATA_W'(cur + st[DATA_W-1:0]) : tgt;
      return (-diff > st) ? DATA_W'(cur - st[DATA_W-1:0]) : tgt;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = $signed({{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
      lo = $signed({{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
      if (v > hi)      return hi[DATA_W-1:0];
      else if (v < lo) return lo[DATA_W-1:0];
      else             return v[DATA_W-1:0];
   endfunction

   // registers
   logic [CFG_W-1:0] fwd_limit_ff, rev_limit_ff, turn_limit_ff, turn_thresh_ff;
   logic [CFG_W-1:0] lin_accel_ff, ang_accel_ff, track_ff;

   seq_state_type state_ff, state_in;

   logic signed [DATA_W-1:0] target_lin_ff, target_lin_in;
   logic signed [DATA_W-1:0] target_ang_ff, target_ang_in;
   logic signed [DATA_W-1:0] ramp_lin_ff, ramp_lin_in;
   logic signed [DATA_W-1:0] ramp_ang_ff, ramp_ang_in;
   logic [TMO_W-1:0]         timeout_ff, timeout_in;
   logic                     armed_ff, armed_in;

   logic [DATA_W:0]          ang_abs_ff, ang_abs_in;
   logic                     ang_neg_ff, ang_neg_in;
   logic [CFG_W-1:0]         mag_ff, mag_in;
   logic [DT_W-1:0]          dt_ff, dt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [DATA_W-1:0] rsp_right_ff, rsp_right_in;

   // request decode
   logic                     req_take;
   logic signed [DATA_W:0]   lin_raw, ang_raw, lin_lim, lin_mag;
   logic                     scale;
   logic                     tick_go;
   logic                     out_load;

   // shared units
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic                      div_start;
   logic                      div_done;
   logic [DIV_Q_W-1:0]        div_q;
   logic signed [DATA_W:0]    ang_scaled;
   logic signed [WIDE_W-1:0]  half;
   logic [CFG_W-1:0]          step;

   assign req_take = req_valid & ~req_stall;

   always_comb begin
      lin_raw = req_enable ? $signed({req_linear_cmd[DATA_W-1], req_linear_cmd}) : '0;
      ang_raw = req_enable ? $signed({req_angular_cmd[DATA_W-1], req_angular_cmd}) : '0;
      if (lin_raw > $signed({9'b0, fwd_limit_ff}))
         lin_lim = $signed({9'b0, fwd_limit_ff});
      else if (lin_raw < -$signed({9'b0, rev_limit_ff}))
         lin_lim = -$signed({9'b0, rev_limit_ff});
      else
         lin_lim = lin_raw;
      lin_mag = (lin_lim < 0) ? -lin_lim : lin_lim;
   end

   assign scale    = lin_mag[CFG_W-1:0] > turn_thresh_ff;
   assign tick_go  = (req_elapsed != '0) & armed_ff;
   assign out_load = (state_ff == ST_WHL_OUT) & (~rsp_valid_ff | ~rsp_stall);
   assign step     = mul_p[CFG_W+DT_W-1:DT_W];
   assign half     = WIDE_W'(mul_p >>> (DT_W + 1));
   assign ang_scaled = ang_neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_op == OP_DRIVE) state_in = scale ? ST_CMD_MUL : ST_IDLE;
               else                    state_in = tick_go ? ST_LIN_MUL : ST_IDLE;
            end
         end
         ST_CMD_MUL:   state_in = ST_CMD_START;
         ST_CMD_START: state_in = ST_CMD_DIV;
         ST_CMD_DIV:   state_in = div_done ? ST_CMD_FIN : ST_CMD_DIV;
         ST_CMD_FIN:   state_in = ST_IDLE;
         ST_LIN_MUL:   state_in = ST_ANG_MUL;
         ST_ANG_MUL:   state_in = ST_ANG_RAMP;
         ST_ANG_RAMP:  state_in = ST_WHL_MUL;
         ST_WHL_MUL:   state_in = ST_WHL_OUT;
         ST_WHL_OUT:   state_in = out_load ? ST_IDLE : ST_WHL_OUT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: operand select, divider start, stall
   always_comb begin
      mul_a     = $signed({ramp_ang_ff[DATA_W-1], ramp_ang_ff});
      mul_b     = $signed({1'b0, track_ff});
      div_start = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE:      req_stall = 1'b0;
         ST_CMD_MUL: begin
            mul_a = $signed(ang_abs_ff);
            mul_b = $signed({1'b0, turn_thresh_ff});
         end
         ST_CMD_START: div_start = 1'b1;
         ST_LIN_MUL: begin
            mul_a = $signed({9'b0, lin_accel_ff});
            mul_b = $signed({9'b0, dt_ff});
         end
         ST_ANG_MUL: begin
            mul_a = $signed({9'b0, ang_accel_ff});
            mul_b = $signed({9'b0, dt_ff});
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      target_lin_in = target_lin_ff;
      target_ang_in = target_ang_ff;
      ramp_lin_in   = ramp_lin_ff;
      ramp_ang_in   = ramp_ang_ff;
      timeout_in    = timeout_ff;
      armed_in      = armed_ff;
      ang_abs_in    = ang_abs_ff;
      ang_neg_in    = ang_neg_ff;
      mag_in        = mag_ff;
      dt_in         = dt_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_op == OP_DRIVE) begin
               target_lin_in = lin_lim[DATA_W-1:0];
               if (!scale) target_ang_in = clamp_turn(ang_raw, turn_limit_ff);
               ang_neg_in = ang_raw < 0;
               ang_abs_in = (ang_raw < 0) ? $unsigned(-ang_raw) : $unsigned(ang_raw);
               mag_in     = lin_mag[CFG_W-1:0];
               armed_in   = 1'b1;
               timeout_in = TIMEOUT_LOAD;
            end else if (req_take && req_elapsed != '0) begin
               dt_in = req_elapsed;
               if (timeout_ff > TMO_W'(req_elapsed)) begin
                  timeout_in = timeout_ff - TMO_W'(req_elapsed);
               end else begin
                  timeout_in    = '0;
                  target_lin_in = '0;
                  target_ang_in = '0;
               end
               if (!armed_ff) begin
                  ramp_lin_in = '0;
                  ramp_ang_in = '0;
               end
            end
         end
         ST_CMD_FIN: target_ang_in = clamp_turn(ang_scaled, turn_limit_ff);
         ST_ANG_MUL:
            ramp_lin_in = ramp_next(ramp_lin_ff, target_lin_ff, lin_accel_ff == '0, step);
         ST_ANG_RAMP:
            ramp_ang_in = ramp_next(ramp_ang_ff, target_ang_ff, ang_accel_ff == '0, step);
         ST_WHL_OUT: begin
            if (out_load) begin
               rsp_left_in  = sat32(WIDE_W'(ramp_lin_ff) - half);
               rsp_right_in = sat32(WIDE_W'(ramp_lin_ff) + half);
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         target_lin_ff  <= '0;
         target_ang_ff  <= '0;
         ramp_lin_ff    <= '0;
         ramp_ang_ff    <= '0;
         timeout_ff     <= '0;
         armed_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_limit_ff   <= FWD_LIMIT_RST;
         rev_limit_ff   <= REV_LIMIT_RST;
         turn_limit_ff  <= TURN_LIMIT_RST;
         turn_thresh_ff <= TURN_THRESH_RST;
         lin_accel_ff   <= LIN_ACCEL_RST;
         ang_accel_ff   <= ANG_ACCEL_RST;
         track_ff       <= TRACK_RST;
      end else begin
         state_ff      <= state_in;
         target_lin_ff <= target_lin_in;
         target_ang_ff <= target_ang_in;
         ramp_lin_ff   <= ramp_lin_in;
         ramp_ang_ff   <= ramp_ang_in;
         timeout_ff    <= timeout_in;
         armed_ff      <= armed_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FWD_LIMIT:   fwd_limit_ff   <= csr_data;
               REG_REV_LIMIT:   rev_limit_ff   <= csr_data;
               REG_TURN_LIMIT:  turn_limit_ff  <= csr_data;
               REG_TURN_THRESH: turn_thresh_ff <= csr_data;
               REG_LIN_ACCEL:   lin_accel_ff   <= csr_data;
               REG_ANG_ACCEL:   ang_accel_ff   <= csr_data;
               REG_TRACK:       track_ff       <= csr_data;
               default: ;
            endcase
         end
      end
      ang_abs_ff   <= ang_abs_in;
      ang_neg_ff   <= ang_neg_in;
      mag_ff       <= mag_in;
      dt_ff        <= dt_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   ddvr_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   ddvr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_p[DIV_N_W-1:0]),
      .divisor  (mag_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = rsp_left_ff;
   assign rsp_right_speed = rsp_right_ff;

endmodule
